// File: src/dspt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual servo pulse train package
// Shared types and constants for the two-channel servo pulse-train core.
// ----------------------------------------------------------------------------
package dspt_pkg;

	// Field widths.
	localparam int unsigned HIGH_W   = 16;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned GAP_W    = 20;
	localparam int unsigned TICK_W   = 21;

	// Stream widths.
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 8;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP         = 2'd1;

	localparam logic [PERIOD_W-1:0] SLOT_PERIOD_RESET = 16'd20000;
	localparam logic [GAP_W-1:0]    GAP_RESET         = 20'd0;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [HIGH_W-1:0]  high_time_a;
		logic [HIGH_W-1:0]  high_time_b;
		logic [COUNT_W-1:0] pulse_count_a;
		logic [COUNT_W-1:0] pulse_count_b;
	} item_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] slot_period_ticks;
		logic [GAP_W-1:0]    gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic drive_a;
		logic drive_b;
		logic busy_res;
		logic train_done;
	} result_t;

endpackage

`default_nettype wire

// File: src/dual_servo_pulse_train_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a word accepted on the input stream passes the input register and then the result register.
// Throughput: one word per cycle while the output is not stalled; the tick engine finishes each word in a single pass.
// Reset: arst_n clears the train state and the stream valids at once; the period
// register returns to 20000 ticks and the gap register to zero.
// ----------------------------------------------------------------------------
// Dual servo pulse train core
// Two-channel servo pulse-train generator driven by one-microsecond tick words.
// ----------------------------------------------------------------------------
module dual_servo_pulse_train_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream.
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// tdata from bit 0: high_time_a[15:0], high_time_b[31:16],
	// pulse_count_a[39:32], pulse_count_b[47:40].
	input  wire logic [dspt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// tuser: op (0 = tick, 1 = start a new train).
	input  wire logic                                s_axis_tuser,
	// Output stream.
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// tdata from bit 0: drive_a, drive_b, busy_res, then zero fill.
	output logic [dspt_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// tlast: train_done, set on the final tick of a train.
	output logic                                     m_axis_tlast,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [dspt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dspt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dspt_pkg::*;

	// Input register stage.
	logic  valid_s1;
	item_t item_s1;

	// Result register stage.
	logic    valid_s2;
	result_t res_s2;

	cfg_t    cfg_q;
	result_t res;
	logic    advance;

	// The engine takes the staged word whenever the result register is free or
	// being drained this cycle, so a word can enter on every clock.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// The payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.op            <= op_t'(s_axis_tuser);
			item_s1.high_time_a   <= s_axis_tdata[15:0];
			item_s1.high_time_b   <= s_axis_tdata[31:16];
			item_s1.pulse_count_a <= s_axis_tdata[39:32];
			item_s1.pulse_count_b <= s_axis_tdata[47:40];
		end
	end

	// Configuration registers. Writes to an unknown index are dropped. The new
	// values feed the engine directly, so they apply from the next tick onward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_period_ticks <= SLOT_PERIOD_RESET;
			cfg_q.gap_ticks         <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SLOT_PERIOD: cfg_q.slot_period_ticks <= cfg_data[PERIOD_W-1:0];
				REG_GAP:         cfg_q.gap_ticks         <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	dspt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register: holds a finished word while the consumer stalls, and
	// is reloaded in the same cycle it is drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(OUT_DATA_W-3)'(0), res_s2.busy_res, res_s2.drive_b, res_s2.drive_a};
	assign m_axis_tlast  = res_s2.train_done;

endmodule

`default_nettype wire

// File: src/dspt_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual servo pulse train engine
// Holds the train state and computes one result per item in a single pass.
// ----------------------------------------------------------------------------
module dspt_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire dspt_pkg::item_t item,
	input  wire dspt_pkg::cfg_t  cfg,
	output dspt_pkg::result_t    res
);
	import dspt_pkg::*;

	logic [TICK_W-1:0]  slot_tick_q,  slot_tick_n;
	logic [COUNT_W-1:0] slot_index_q, slot_index_n;
	logic [HIGH_W-1:0]  high_a_q, high_b_q;
	logic [COUNT_W-1:0] count_a_q, count_b_q;
	logic               running_q, running_n;

	logic [COUNT_W-1:0] count_max;
	logic [HIGH_W-1:0]  clamp_a, clamp_b;
	logic [TICK_W-1:0]  slot_len;
	logic [TICK_W-1:0]  last_pos;
	logic [COUNT_W:0]   index_inc;

	always_comb begin
		count_max = (count_a_q > count_b_q) ? count_a_q : count_b_q;
		clamp_a   = (high_a_q > cfg.slot_period_ticks) ? cfg.slot_period_ticks : high_a_q;
		clamp_b   = (high_b_q > cfg.slot_period_ticks) ? cfg.slot_period_ticks : high_b_q;
		slot_len  = TICK_W'(cfg.slot_period_ticks) + TICK_W'(cfg.gap_ticks);
		// A zero-length slot behaves as a one-tick slot.
		last_pos  = (slot_len == '0) ? '0 : slot_len - TICK_W'(1);
		index_inc = {1'b0, slot_index_q} + (COUNT_W+1)'(1);
	end

	always_comb begin
		res          = '0;
		slot_tick_n  = slot_tick_q;
		slot_index_n = slot_index_q;
		running_n    = running_q;
		if (item.op == OP_START) begin
			slot_tick_n  = '0;
			slot_index_n = '0;
			running_n    = (item.pulse_count_a != '0) || (item.pulse_count_b != '0);
			res.busy_res = running_n;
		end else if (running_q) begin
			res.drive_a  = (slot_index_q < count_a_q) && (slot_tick_q < TICK_W'(clamp_a));
			res.drive_b  = (slot_index_q < count_b_q) && (slot_tick_q < TICK_W'(clamp_b));
			res.busy_res = 1'b1;
			if (slot_tick_q >= last_pos) begin
				slot_tick_n = '0;
				if (index_inc >= {1'b0, count_max}) begin
					res.train_done = 1'b1;
					running_n      = 1'b0;
					slot_index_n   = '0;
				end else begin
					slot_index_n = index_inc[COUNT_W-1:0];
				end
			end else begin
				slot_tick_n = slot_tick_q + TICK_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_tick_q  <= '0;
			slot_index_q <= '0;
			high_a_q     <= '0;
			high_b_q     <= '0;
			count_a_q    <= '0;
			count_b_q    <= '0;
			running_q    <= 1'b0;
		end else if (step) begin
			slot_tick_q  <= slot_tick_n;
			slot_index_q <= slot_index_n;
			running_q    <= running_n;
			if (item.op == OP_START) begin
				high_a_q  <= item.high_time_a;
				high_b_q  <= item.high_time_b;
				count_a_q <= item.pulse_count_a;
				count_b_q <= item.pulse_count_b;
			end
		end
	end

	// A running train always sits in a slot that at least one channel still owns.
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> ((slot_index_q < count_a_q) || (slot_index_q < count_b_q)))
		else $error("slot index beyond both pulse counts");

	// Outputs only toggle while a train is in progress.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (res.drive_a || res.drive_b || res.train_done)) |-> res.busy_res)
		else $error("drive or done without busy");

	// The final tick of a train returns the engine to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.train_done) |=> !running_q)
		else $error("still running after train done");

	// Idle ticks produce an all-zero result.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!running_q && item.op == OP_TICK) |-> (res == '0))
		else $error("nonzero result while idle");

endmodule

`default_nettype wire
